// ===== rtl/ptbl_pkg.sv =====
// Shared types and constants of the per-source token bucket limiter.
package ptbl_pkg;

  // Field widths
  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned TIME_W  = 63;
  localparam int unsigned TOK_W   = 40;
  localparam int unsigned TOUT_W  = 48;
  localparam int unsigned FAM_W   = 2;
  localparam int unsigned CFG_W   = 64;
  localparam int unsigned PADDR_W = 6;

  // Opcodes
  localparam logic OP_CHECK = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Address families
  localparam logic [FAM_W-1:0] FAM_V4 = 2'd0;
  localparam logic [FAM_W-1:0] FAM_V6 = 2'd1;

  // Result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_BADFAM = 2'd3;

  // Register indexes (byte address 8*i)
  localparam logic [2:0] REG_KEY_LO   = 3'd0;
  localparam logic [2:0] REG_KEY_HI   = 3'd1;
  localparam logic [2:0] REG_COST     = 3'd2;
  localparam logic [2:0] REG_CAPACITY = 3'd3;
  localparam logic [2:0] REG_TIMEOUT  = 3'd4;

  // Register reset values
  localparam logic [TOK_W-1:0]  COST_RST     = 40'd214748364;
  localparam logic [TOK_W-1:0]  CAPACITY_RST = 40'd1073741820;
  localparam logic [TOUT_W-1:0] TIMEOUT_RST  = 48'd4294967296;

  // SipHash initialization constants
  localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
  localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
  localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
  localparam logic [63:0] SIP_C3 = 64'h7465646279746573;

  // One way of a table set
  typedef struct packed {
    logic              valid;
    logic              fam;
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] last;
    logic [TOK_W-1:0]  tokens;
  } entry_t;

  // Hash start request
  typedef struct packed {
    logic              start;
    logic              v6;
    logic [ADDR_W-1:0] addr;
  } hash_req_t;

  // Set lookup outcome
  typedef struct packed {
    logic hit;
    logic free;
  } look_t;

endpackage

// ===== rtl/ptbl_siphash.sv =====
// Iterative SipHash-1-3 unit, one half round per cycle.
module ptbl_siphash import ptbl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [63:0] key0_i,
  input  logic [63:0] key1_i,
  input  hash_req_t   req_i,
  output logic        done_o,
  output logic [63:0] hash_o
);

  typedef struct packed {
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] v2;
    logic [63:0] v3;
  } sip_t;

  // First half of a SipRound
  function automatic sip_t half_a(sip_t v);
    sip_t r;
    logic [63:0] s0;
    logic [63:0] s2;
    s0   = v.v0 + v.v1;
    s2   = v.v2 + v.v3;
    r.v1 = {v.v1[50:0], v.v1[63:51]} ^ s0;
    r.v0 = {s0[31:0], s0[63:32]};
    r.v3 = {v.v3[47:0], v.v3[63:48]} ^ s2;
    r.v2 = s2;
    return r;
  endfunction

  // Second half of a SipRound
  function automatic sip_t half_b(sip_t v);
    sip_t r;
    logic [63:0] s0;
    logic [63:0] s2;
    s0   = v.v0 + v.v3;
    s2   = v.v2 + v.v1;
    r.v0 = s0;
    r.v3 = {v.v3[42:0], v.v3[63:43]} ^ s0;
    r.v1 = {v.v1[46:0], v.v1[63:47]} ^ s2;
    r.v2 = {s2[31:0], s2[63:32]};
    return r;
  endfunction

  sip_t        v_q;
  sip_t        va, vb;
  logic [63:0] m_q, m2_q;
  logic        more_q, msg_q, half_q, busy_q, done_q;
  logic [1:0]  fin_q;
  logic [63:0] hash_q;
  logic [63:0] w_first, w_last;
  sip_t        v_init;

  // Message words in little-endian byte order, length in the top byte
  always_comb begin
    if (req_i.v6) begin
      w_first = {req_i.addr[7:0], req_i.addr[15:8], req_i.addr[23:16], req_i.addr[31:24],
                 req_i.addr[39:32], req_i.addr[47:40], req_i.addr[55:48], req_i.addr[63:56]};
      w_last  = {8'd8, 56'd0};
    end else begin
      w_first = {8'd4, 24'd0, req_i.addr[7:0], req_i.addr[15:8], req_i.addr[23:16],
                 req_i.addr[31:24]};
      w_last  = w_first;
    end
    v_init.v0 = key0_i ^ SIP_C0;
    v_init.v1 = key1_i ^ SIP_C1;
    v_init.v2 = key0_i ^ SIP_C2;
    v_init.v3 = key1_i ^ SIP_C3 ^ w_first;
    va = half_a(v_q);
    vb = half_b(v_q);
  end

  // Round sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      half_q <= 1'b0;
      msg_q  <= 1'b0;
      more_q <= 1'b0;
      fin_q  <= 2'd0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        v_q    <= v_init;
        m_q    <= w_first;
        m2_q   <= w_last;
        more_q <= req_i.v6;
        msg_q  <= 1'b1;
        fin_q  <= 2'd0;
        half_q <= 1'b0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (!half_q) begin
          v_q    <= va;
          half_q <= 1'b1;
        end else begin
          half_q <= 1'b0;
          if (msg_q) begin
            // finish absorbing, then load next word or start finalization
            if (more_q) begin
              v_q    <= '{v0: vb.v0 ^ m_q, v1: vb.v1, v2: vb.v2, v3: vb.v3 ^ m2_q};
              m_q    <= m2_q;
              more_q <= 1'b0;
            end else begin
              v_q   <= '{v0: vb.v0 ^ m_q, v1: vb.v1, v2: vb.v2 ^ 64'hFF, v3: vb.v3};
              msg_q <= 1'b0;
            end
          end else begin
            v_q <= vb;
            if (fin_q == 2'd2) begin
              busy_q <= 1'b0;
              done_q <= 1'b1;
              hash_q <= vb.v0 ^ vb.v1 ^ vb.v2 ^ vb.v3;
            end else begin
              fin_q <= fin_q + 2'd1;
            end
          end
        end
      end
    end
  end

  assign done_o = done_q;
  assign hash_o = hash_q;

endmodule

// ===== rtl/ptbl_table.sv =====
// Set-associative bucket table: row memory plus way match and free-way search.
module ptbl_table import ptbl_pkg::*; #(
  parameter int unsigned NUM_SETS = 1024,
  parameter int unsigned NUM_WAYS = 4,
  parameter int unsigned SET_W    = 10,
  parameter int unsigned WAY_W    = 2
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      rd_en_i,
  input  logic [SET_W-1:0]          rd_set_i,
  input  logic                      wr_en_i,
  input  logic [SET_W-1:0]          wr_set_i,
  input  entry_t [NUM_WAYS-1:0]     wr_row_i,
  input  logic                      fam_i,
  input  logic [ADDR_W-1:0]         addr_i,
  input  logic [TIME_W-1:0]         now_i,
  input  logic [TOUT_W-1:0]         timeout_i,
  output entry_t [NUM_WAYS-1:0]     row_o,
  output look_t                     look_o,
  output logic [WAY_W-1:0]          way_o,
  output logic [TIME_W-1:0]         elapsed_o
);

  entry_t [NUM_WAYS-1:0] mem [NUM_SETS];
  entry_t [NUM_WAYS-1:0] rdata_q;

  // Row memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_set_i] <= wr_row_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_set_i];
    end
  end

  look_t             look_d, look_q;
  logic [WAY_W-1:0]  hit_way, free_way, way_q;
  logic [TIME_W-1:0] hit_el, el_q;
  logic [TIME_W-1:0] el [NUM_WAYS];

  // Per-way elapsed time, match and reuse checks; lowest way wins
  always_comb begin
    look_d   = '0;
    hit_way  = '0;
    free_way = '0;
    hit_el   = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      el[w] = (now_i >= rdata_q[w].last) ? now_i - rdata_q[w].last : '0;
      if (rdata_q[w].valid && rdata_q[w].fam == fam_i && rdata_q[w].addr == addr_i) begin
        look_d.hit = 1'b1;
        hit_way    = WAY_W'(w);
        hit_el     = el[w];
      end
      if (!rdata_q[w].valid || el[w] > {{(TIME_W-TOUT_W){1'b0}}, timeout_i}) begin
        look_d.free = 1'b1;
        free_way    = WAY_W'(w);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      look_q <= '0;
    end else begin
      look_q <= look_d;
    end
  end

  always_ff @(posedge clk_i) begin
    way_q <= look_d.hit ? hit_way : free_way;
    el_q  <= hit_el;
  end

  assign row_o     = rdata_q;
  assign look_o    = look_q;
  assign way_o     = way_q;
  assign elapsed_o = el_q;

endmodule

// ===== rtl/per_source_token_bucket_limiter.sv =====
// Top level of the per-source token bucket limiter.
//
// Input channel (in_valid_i/in_ready_o) takes one item per transfer: a check
// request (opcode 0) or a table flush (opcode 1). Output channel
// (out_valid_o/out_ready_i) returns exactly one result per item, in order.
// Items are processed one at a time. A check request runs SipHash-1-3 on a
// shared unit at one half round per cycle (one SipRound per message word,
// then three finalization rounds), then a set read, a wait state, a lookup
// and, on a hit, a refill step; a new entry is written back at the lookup,
// a refilled bucket at the refill step. A bad family skips the hash and the
// table. A flush clears the table one set per cycle, then answers.
// After reset the same clearing pass runs over every set before in_ready_o
// rises; APB register writes are taken throughout.
// The result sits in an output register, so a stalled receiver does not stop
// the next item from being taken and worked on; only its result waits.
// Registers (APB, 64-bit, byte address 8*i): key low, key high, request
// cost, bucket capacity, idle timeout. Write them only while idle.
module per_source_token_bucket_limiter import ptbl_pkg::*; #(
  parameter int unsigned NUM_SETS = 1024,
  parameter int unsigned NUM_WAYS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               opcode_i,
  input  logic [FAM_W-1:0]   addr_family_i,
  input  logic [ADDR_W-1:0]  source_address_i,
  input  logic [TIME_W-1:0]  now_time_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               allowed_o,
  output logic [1:0]         status_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [CFG_W-1:0]   pwdata,
  output logic [CFG_W-1:0]   prdata,
  output logic               pready
);

  localparam int unsigned SET_W = $clog2(NUM_SETS);
  localparam int unsigned WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_HASH, S_READ, S_WAIT, S_LOOK, S_UPD, S_DONE
  } state_e;

  state_e              state_q;
  logic [SET_W-1:0]    clr_q, set_q;
  logic                flush_q;
  logic                fam_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [TIME_W-1:0]   now_q;
  logic [TOK_W-1:0]    tok_q;
  logic                res_allow_q;
  logic [1:0]          res_status_q;
  logic                out_valid_q, out_allowed_q;
  logic [1:0]          out_status_q;
  logic [63:0]         key0_q, key1_q;
  logic [TOK_W-1:0]    cost_q, cap_q;
  logic [TOUT_W-1:0]   tout_q;

  // Configuration port
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[5:3])
      REG_KEY_LO:   prdata = key0_q;
      REG_KEY_HI:   prdata = key1_q;
      REG_COST:     prdata = {{(CFG_W-TOK_W){1'b0}}, cost_q};
      REG_CAPACITY: prdata = {{(CFG_W-TOK_W){1'b0}}, cap_q};
      REG_TIMEOUT:  prdata = {{(CFG_W-TOUT_W){1'b0}}, tout_q};
      default:      prdata = '0;
    endcase
  end

  // Hash unit
  logic        in_xfer;
  hash_req_t   hreq;
  logic        hash_done;
  logic [63:0] hash;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign hreq.start = in_xfer && opcode_i == OP_CHECK &&
                      (addr_family_i == FAM_V4 || addr_family_i == FAM_V6);
  assign hreq.v6    = (addr_family_i == FAM_V6);
  assign hreq.addr  = source_address_i;

  ptbl_siphash u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .key0_i (key0_q),
    .key1_i (key1_q),
    .req_i  (hreq),
    .done_o (hash_done),
    .hash_o (hash)
  );

  // Table
  logic                  rd_en, wr_en;
  logic [SET_W-1:0]      wr_set;
  entry_t [NUM_WAYS-1:0] wr_row, row;
  look_t                 look;
  logic [WAY_W-1:0]      way;
  logic [TIME_W-1:0]     elapsed;

  ptbl_table #(
    .NUM_SETS (NUM_SETS),
    .NUM_WAYS (NUM_WAYS),
    .SET_W    (SET_W),
    .WAY_W    (WAY_W)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_set_i  (set_q),
    .wr_en_i   (wr_en),
    .wr_set_i  (wr_set),
    .wr_row_i  (wr_row),
    .fam_i     (fam_q),
    .addr_i    (addr_q),
    .now_i     (now_q),
    .timeout_i (tout_q),
    .row_o     (row),
    .look_o    (look),
    .way_o     (way),
    .elapsed_o (elapsed)
  );

  // Bucket arithmetic
  logic [63:0]      tok_sum;
  logic [TOK_W-1:0] tok_d, tok_new, tok_upd;
  logic             tok_ok;
  entry_t           ent;

  always_comb begin
    tok_sum = {{(64-TOK_W){1'b0}}, row[way].tokens} + {{(64-TIME_W){1'b0}}, elapsed};
    tok_d   = (tok_sum > {{(64-TOK_W){1'b0}}, cap_q}) ? cap_q : tok_sum[TOK_W-1:0];
    tok_new = (cap_q >= cost_q) ? cap_q - cost_q : '0;
    tok_ok  = (tok_q >= cost_q);
    tok_upd = tok_ok ? tok_q - cost_q : tok_q;
    ent.valid  = 1'b1;
    ent.fam    = fam_q;
    ent.addr   = addr_q;
    ent.last   = now_q;
    ent.tokens = (state_q == S_UPD) ? tok_upd : tok_new;
  end

  // Memory port control: clearing pass, new entry, refill write-back
  always_comb begin
    rd_en  = (state_q == S_READ);
    wr_en  = 1'b0;
    wr_set = set_q;
    wr_row = row;
    wr_row[way] = ent;
    case (state_q)
      S_CLEAR: begin
        wr_en  = 1'b1;
        wr_set = clr_q;
        wr_row = '0;
      end
      S_LOOK:  wr_en = !look.hit && look.free;
      S_UPD:   wr_en = 1'b1;
      default: wr_en = 1'b0;
    endcase
  end

  // Sequencer, configuration and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      flush_q     <= 1'b0;
      out_valid_q <= 1'b0;
      key0_q      <= '0;
      key1_q      <= '0;
      cost_q      <= COST_RST;
      cap_q       <= CAPACITY_RST;
      tout_q      <= TIMEOUT_RST;
    end else begin
      if (cfg_wr) begin
        case (paddr[5:3])
          REG_KEY_LO:   key0_q <= pwdata;
          REG_KEY_HI:   key1_q <= pwdata;
          REG_COST:     cost_q <= pwdata[TOK_W-1:0];
          REG_CAPACITY: cap_q  <= pwdata[TOK_W-1:0];
          REG_TIMEOUT:  tout_q <= pwdata[TOUT_W-1:0];
          default:      ;
        endcase
      end
      // result leaves; in S_DONE the hand-over below sets the flag instead
      if (out_valid_q && out_ready_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == {SET_W{1'b1}}) begin
            res_allow_q  <= 1'b0;
            res_status_q <= ST_OK;
            state_q      <= flush_q ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            fam_q  <= addr_family_i[0];
            addr_q <= (addr_family_i == FAM_V4) ?
                      {32'd0, source_address_i[31:0]} : source_address_i;
            now_q  <= now_time_i;
            if (opcode_i == OP_FLUSH) begin
              flush_q <= 1'b1;
              clr_q   <= '0;
              state_q <= S_CLEAR;
            end else if (hreq.start) begin
              state_q <= S_HASH;
            end else begin
              res_allow_q  <= 1'b0;
              res_status_q <= ST_BADFAM;
              state_q      <= S_DONE;
            end
          end
        end
        S_HASH: begin
          if (hash_done) begin
            set_q   <= hash[SET_W-1:0];
            state_q <= S_READ;
          end
        end
        S_READ: state_q <= S_WAIT;
        S_WAIT: state_q <= S_LOOK;
        S_LOOK: begin
          if (look.hit) begin
            tok_q   <= tok_d;
            state_q <= S_UPD;
          end else begin
            res_allow_q  <= look.free;
            res_status_q <= look.free ? ST_OK : ST_FULL;
            state_q      <= S_DONE;
          end
        end
        S_UPD: begin
          res_allow_q  <= tok_ok;
          res_status_q <= tok_ok ? ST_OK : ST_EMPTY;
          state_q      <= S_DONE;
        end
        S_DONE: begin
          // hand the result over once the output register is free
          if (!out_valid_q || out_ready_i) begin
            out_valid_q   <= 1'b1;
            out_allowed_q <= res_allow_q;
            out_status_q  <= res_status_q;
            flush_q       <= 1'b0;
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign allowed_o   = out_allowed_q;
  assign status_o    = out_status_q;

endmodule

// ===== rtl/ptbl_checker.sv =====
// Port-level checks of the limiter, bound to the top level.
module ptbl_checker import ptbl_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               allowed_o,
  input logic [1:0]         status_o,
  input logic               pready
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(allowed_o) && $stable(status_o))
    else $error("result changed while stalled");

  // Only an ok status may allow
  a_allow_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && allowed_o |-> status_o == ST_OK)
    else $error("allowed with non-ok status");

  // One item at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken while busy");

  // Register port never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind per_source_token_bucket_limiter ptbl_checker u_ptbl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .allowed_o   (allowed_o),
  .status_o    (status_o),
  .pready      (pready)
);

// ===== tb/testbench.sv =====
// Self-checking testbench of the per-source token bucket limiter.
`timescale 1ns / 100ps

module testbench;
  import ptbl_pkg::*;

  localparam int unsigned NUM_SETS = 1024;
  localparam int unsigned NUM_WAYS = 4;
  localparam int unsigned DEPTH    = NUM_SETS * NUM_WAYS;
  localparam int unsigned DRAIN_CYCLES = NUM_SETS + 64;
  localparam int unsigned PHASE_ITEMS  = 120;

  typedef struct packed {
    logic              op;
    logic [FAM_W-1:0]  fam;
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] tm;
  } item_t;

  typedef struct packed {
    logic       allowed;
    logic [1:0] status;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic opcode_i = OP_CHECK;
  logic [FAM_W-1:0] addr_family_i = FAM_V4;
  logic [ADDR_W-1:0] source_address_i = '0;
  logic [TIME_W-1:0] now_time_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic allowed_o;
  logic [1:0] status_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [CFG_W-1:0] pwdata = '0;
  logic [CFG_W-1:0] prdata;
  logic pready;

  per_source_token_bucket_limiter #(.NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS)) dut (.*);

  // Clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow of the registers and the table
  logic [63:0] key_lo, key_hi;
  logic [TOK_W-1:0] cost, capacity;
  logic [TOUT_W-1:0] timeout;
  logic tbl_valid [DEPTH];
  logic tbl_fam [DEPTH];
  logic [ADDR_W-1:0] tbl_addr [DEPTH];
  logic [TIME_W-1:0] tbl_last [DEPTH];
  logic [TOK_W-1:0] tbl_tokens [DEPTH];

  item_t pending_items[$];
  verdict_t expected_verdicts[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit in_xfer = 1'b0;

  function automatic logic [63:0] rotl(logic [63:0] x, int b);
    return (x << b) | (x >> (64 - b));
  endfunction

  function automatic logic [255:0] sip_round(logic [255:0] s);
    logic [63:0] v0, v1, v2, v3;
    {v0, v1, v2, v3} = s;
    v0 += v1; v1 = rotl(v1, 13); v1 ^= v0; v0 = rotl(v0, 32);
    v2 += v3; v3 = rotl(v3, 16); v3 ^= v2;
    v0 += v3; v3 = rotl(v3, 21); v3 ^= v0;
    v2 += v1; v1 = rotl(v1, 17); v1 ^= v2; v2 = rotl(v2, 32);
    return {v0, v1, v2, v3};
  endfunction

  function automatic logic [255:0] sip_absorb(logic [255:0] s, logic [63:0] m);
    s[63:0] ^= m;
    s = sip_round(s);
    s[255:192] ^= m;
    return s;
  endfunction

  // SipHash-1-3 of the address bytes, first byte first
  function automatic int unsigned set_of(logic v6, logic [63:0] a);
    logic [255:0] s;
    logic [63:0] h;
    s = {key_lo ^ SIP_C0, key_hi ^ SIP_C1, key_lo ^ SIP_C2, key_hi ^ SIP_C3};
    if (v6) begin
      s = sip_absorb(s, {a[7:0], a[15:8], a[23:16], a[31:24],
                         a[39:32], a[47:40], a[55:48], a[63:56]});
      s = sip_absorb(s, {8'd8, 56'd0});
    end else begin
      s = sip_absorb(s, {8'd4, 24'd0, a[7:0], a[15:8], a[23:16], a[31:24]});
    end
    s[127:64] ^= 64'hFF;
    s = sip_round(s);
    s = sip_round(s);
    s = sip_round(s);
    h = s[255:192] ^ s[191:128] ^ s[127:64] ^ s[63:0];
    return int'(h & (NUM_SETS - 1));
  endfunction

  // Verdict of one item; updates the shadow table
  function automatic verdict_t limit_verdict(item_t it);
    verdict_t r;
    logic [ADDR_W-1:0] a;
    logic [63:0] elapsed, tok;
    int unsigned base, e;
    int free_way;
    r = '{allowed: 1'b0, status: ST_OK};
    free_way = -1;
    if (it.op == OP_FLUSH) begin
      foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
      return r;
    end
    if (it.fam != FAM_V4 && it.fam != FAM_V6) begin
      r.status = ST_BADFAM;
      return r;
    end
    a = (it.fam == FAM_V4) ? {32'd0, it.addr[31:0]} : it.addr;
    base = set_of(it.fam == FAM_V6, a) * NUM_WAYS;
    for (int w = 0; w < NUM_WAYS; w++) begin
      e = base + w;
      if (!tbl_valid[e]) begin
        if (free_way < 0) free_way = w;
        continue;
      end
      elapsed = (it.tm >= tbl_last[e]) ? 64'(it.tm - tbl_last[e]) : 64'd0;
      if (tbl_fam[e] == it.fam[0] && tbl_addr[e] == a) begin
        tok = 64'(tbl_tokens[e]) + elapsed;
        if (tok > 64'(capacity)) tok = 64'(capacity);
        tbl_last[e] = it.tm;
        if (tok >= 64'(cost)) begin
          tbl_tokens[e] = TOK_W'(tok - 64'(cost));
          r.allowed = 1'b1;
        end else begin
          tbl_tokens[e] = TOK_W'(tok);
          r.status = ST_EMPTY;
        end
        return r;
      end
      if (free_way < 0 && elapsed > 64'(timeout)) free_way = w;
    end
    if (free_way < 0) begin
      r.status = ST_FULL;
      return r;
    end
    e = base + free_way;
    tbl_valid[e] = 1'b1;
    tbl_fam[e] = it.fam[0];
    tbl_addr[e] = a;
    tbl_last[e] = it.tm;
    tbl_tokens[e] = (capacity >= cost) ? capacity - cost : '0;
    r.allowed = 1'b1;
    return r;
  endfunction

  // Driver: item channel and receiver readiness, changed at the falling edge
  always @(negedge clk_i) begin
    if (in_valid_i && !in_xfer) begin
      in_valid_i <= 1'b1;
    end else if (rst_ni && pending_items.size() != 0 &&
                 $urandom_range(99) >= send_idle_pct) begin
      item_t it;
      it = pending_items.pop_front();
      opcode_i <= it.op;
      addr_family_i <= it.fam;
      source_address_i <= it.addr;
      now_time_i <= it.tm;
      in_valid_i <= 1'b1;
    end else begin
      in_valid_i <= 1'b0;
    end
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: predict on each item transfer, check each result transfer
  always @(posedge clk_i) begin
    in_xfer = in_valid_i && in_ready_o;
    if (out_valid_o && out_ready_i) begin
      if (expected_verdicts.size() == 0) begin
        $error("result transfer with no result expected");
        errors++;
      end else begin
        verdict_t x;
        x = expected_verdicts.pop_front();
        if (allowed_o !== x.allowed) begin
          $error("allowed: expected %0d, actual %0d", x.allowed, allowed_o);
          errors++;
        end
        if (status_o !== x.status) begin
          $error("status: expected %0d, actual %0d", x.status, status_o);
          errors++;
        end
      end
    end
    if (in_xfer)
      expected_verdicts.push_back(limit_verdict('{op: opcode_i, fam: addr_family_i,
          addr: source_address_i, tm: now_time_i}));
  end

  // APB register write, setup then access
  task automatic write_reg(logic [2:0] idx, logic [63:0] value);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= PADDR_W'(idx) << 3; pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_KEY_LO:   key_lo = value;
      REG_KEY_HI:   key_hi = value;
      REG_COST:     cost = value[TOK_W-1:0];
      REG_CAPACITY: capacity = value[TOK_W-1:0];
      REG_TIMEOUT:  timeout = value[TOUT_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic configure(logic [63:0] k0, logic [63:0] k1, logic [63:0] c,
                           logic [63:0] cap, logic [63:0] tout);
    write_reg(REG_KEY_LO, k0);
    write_reg(REG_KEY_HI, k1);
    write_reg(REG_COST, c);
    write_reg(REG_CAPACITY, cap);
    write_reg(REG_TIMEOUT, tout);
  endtask

  // Wait until every item is sent and answered, then let the block settle
  task automatic drain();
    wait (pending_items.size() == 0 && !in_valid_i && expected_verdicts.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic item_t check_item(logic [FAM_W-1:0] f, logic [63:0] a,
                                       logic [TIME_W-1:0] t);
    return '{op: OP_CHECK, fam: f, addr: a, tm: t};
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // An IPv4 address with random upper bits that falls in the given set
  function automatic logic [63:0] v4_in_set(int unsigned s);
    logic [63:0] a;
    do a = rand64(); while (set_of(1'b0, {32'd0, a[31:0]}) != s);
    return a;
  endfunction

  // Advance the running time: mostly short steps, some long, a few backwards
  function automatic logic [TIME_W-1:0] next_time(logic [TIME_W-1:0] t);
    int r;
    logic [63:0] step;
    r = $urandom_range(99);
    if (r < 50) step = 64'($urandom_range(32'h00FF_FFFF));
    else if (r < 85) step = 64'($urandom & 32'h0FFF_FFFF);
    else if (r < 95) step = {31'd0, 1'($urandom_range(1)), $urandom};
    else return (t > 63'd5000) ? t - 63'($urandom_range(5000)) : t;
    if (64'(t) + step > 64'h7FFF_FFFF_FFFF_FFFF) return '1;
    return t + TIME_W'(step);
  endfunction

  initial begin
    #400_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [TIME_W-1:0] t;
    logic [63:0] grp [5];
    logic [63:0] pool [6];
    logic [FAM_W-1:0] pool_fam [6];
    logic [63:0] a;
    logic [39:0] c;
    int unsigned s;
    int r, k;

    key_lo = '0; key_hi = '0;
    cost = COST_RST; capacity = CAPACITY_RST; timeout = TIMEOUT_RST;
    foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under reset register values
    t = 63'({$urandom_range(255), $urandom});
    a = rand64();
    s = $urandom_range(NUM_SETS - 1);
    foreach (grp[i]) grp[i] = v4_in_set(s);
    pending_items.push_back('{op: OP_FLUSH, fam: 2'd3, addr: '1, tm: '1});
    pending_items.push_back(check_item(2'd2, rand64(), t));
    pending_items.push_back(check_item(2'd3, rand64(), t));
    // bucket drains, then refuses
    for (int i = 0; i < 7; i++) pending_items.push_back(check_item(FAM_V4, a, t + i));
    // time going backwards, then a full refill
    pending_items.push_back(check_item(FAM_V4, a, t - 63'd1000));
    pending_items.push_back(check_item(FAM_V4, a, t + 63'(capacity) * 2));
    pending_items.push_back(check_item(FAM_V6, '0, t));
    pending_items.push_back(check_item(FAM_V4, '0, t));
    pending_items.push_back(check_item(FAM_V6, '1, t));
    // set fills, fifth source refused, then takes an idle way
    foreach (grp[i]) pending_items.push_back(check_item(FAM_V4, grp[i], t + 10));
    pending_items.push_back(check_item(FAM_V4, grp[4], t + 63'(timeout) * 2));
    pending_items.push_back(check_item(FAM_V6, '1, '1));
    pending_items.push_back('{op: OP_FLUSH, fam: '0, addr: '0, tm: '0});
    drain();

    for (int p = 1; p <= 8; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      c = 40'({$urandom_range(63), $urandom}) & 40'h00_7FFF_FFFF;
      case (p)
        1: configure(rand64(), rand64(), COST_RST, CAPACITY_RST, TIMEOUT_RST);
        2: configure('0, '1, 0, 0, 0);
        3: configure('1, '0, '1, '1, '1);
        4: configure(rand64(), rand64(), 64'(c) + 64'd1000, c, 64'($urandom_range(1 << 24)));
        default: configure(rand64(), rand64(), c, 64'(c) * $urandom_range(1, 8),
                           {$urandom_range(3), $urandom});
      endcase
      t = ($urandom_range(3) == 0) ? {1'b1, 62'(rand64())} & 63'h7FFF_FFF0_0000_0000
                                   : 63'({$urandom_range(255), $urandom});
      s = $urandom_range(NUM_SETS - 1);
      foreach (grp[i]) grp[i] = v4_in_set(s);
      foreach (pool[i]) begin
        pool[i] = rand64();
        pool_fam[i] = $urandom_range(1) ? FAM_V6 : FAM_V4;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(99);
        t = next_time(t);
        if (r < 4) begin
          pending_items.push_back('{op: OP_FLUSH, fam: FAM_W'($urandom),
                                    addr: rand64(), tm: TIME_W'(rand64())});
        end else if (r < 9) begin
          pending_items.push_back(check_item(2'd2 | FAM_W'($urandom_range(1)), rand64(), t));
        end else if (r < 55) begin
          k = $urandom_range(5);
          a = pool[k];
          if (pool_fam[k] == FAM_V4) a[63:32] = $urandom;
          pending_items.push_back(check_item(pool_fam[k], a, t));
        end else begin
          a = grp[$urandom_range(4)];
          a[63:32] = $urandom;
          pending_items.push_back(check_item(FAM_V4, a, t));
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
